// ----- hw/rtl/cartesian_to_spherical_assert.svh -----
// ---------------------------------------------------------------------------
// Cartesian to spherical assertion macros
// Short forms for the concurrent checks of the conversion pipeline.
// ---------------------------------------------------------------------------
`ifndef CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C2S_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cartesian_to_spherical check failed");

// The consequent must hold in the cycle after the antecedent.
`define C2S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cartesian_to_spherical check failed");

`endif

// ----- hw/rtl/c2s_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cartesian to spherical package
// Widths, angle constants, the CORDIC arctangent table and the sideband
// word that travels with each position through the pipeline.
// ---------------------------------------------------------------------------
package c2s_pkg;

   // Fraction bits of positions and angles; the port widths are sized for it.
   localparam int FRAC_BITS = 16;

   localparam int POS_W    = 24;
   localparam int HEIGHT_W = 21;
   localparam int AZ_W     = 19;
   localparam int EL_W     = 18;
   localparam int SQ_W     = 48;
   localparam int ROOT_W   = 24;
   localparam int REM_W    = 25;
   localparam int CW       = 60;
   localparam int ACC_W    = 36;
   localparam int SCALE_SH = 32;
   localparam int EXT_W    = 26;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   localparam logic signed [EXT_W-1:0] POS_MAX = 26'sd8388607;
   localparam logic signed [EXT_W-1:0] POS_MIN = -26'sd8388608;

   // Sideband word carried alongside the square root and CORDIC stages.
   typedef struct packed {
      logic signed [POS_W:0]   ax;
      logic signed [POS_W:0]   ay;
      logic                    x_neg;
      logic                    y_neg;
      logic signed [POS_W-1:0] pos_z;
      logic signed [POS_W-1:0] raised_z;
      logic                    h_zero;
      logic                    zero;
      logic [ROOT_W-1:0]       distance;
      logic [ROOT_W-1:0]       horizontal;
   } side_type;

   // atan(2^-i) in Q30, truncated.
   function automatic logic signed [ACC_W-1:0] atan_q30(input int idx);
      logic signed [ACC_W-1:0] val;
      unique case (idx)
         0:  val = 36'sd843314856;
         1:  val = 36'sd497837829;
         2:  val = 36'sd263043836;
         3:  val = 36'sd133525158;
         4:  val = 36'sd67021686;
         5:  val = 36'sd33543515;
         6:  val = 36'sd16775850;
         7:  val = 36'sd8388437;
         8:  val = 36'sd4194282;
         9:  val = 36'sd2097149;
         10: val = 36'sd1048575;
         11: val = 36'sd524287;
         12: val = 36'sd262143;
         13: val = 36'sd131071;
         14: val = 36'sd65535;
         15: val = 36'sd32767;
         16: val = 36'sd16383;
         17: val = 36'sd8191;
         18: val = 36'sd4095;
         19: val = 36'sd2047;
         20: val = 36'sd1023;
         21: val = 36'sd511;
         22: val = 36'sd255;
         23: val = 36'sd127;
         24: val = 36'sd63;
         25: val = 36'sd31;
         26: val = 36'sd15;
         27: val = 36'sd7;
         28: val = 36'sd3;
         29: val = 36'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- hw/rtl/c2s_sqrt_stage.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Square root digit step
// One restoring step of the integer square root: takes the next two
// radicand bits and decides one root bit.
// ---------------------------------------------------------------------------
module c2s_sqrt_stage
   import c2s_pkg::*;
(
   input  logic [REM_W-1:0]  rem_in,
   input  logic [ROOT_W-1:0] root_in,
   input  logic [SQ_W-1:0]   rad_in,
   output logic [REM_W-1:0]  rem_out,
   output logic [ROOT_W-1:0] root_out,
   output logic [SQ_W-1:0]   rad_out
);

   logic [REM_W+1:0] rem_shift;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] diff;

   // Bring down the next bit pair and form the trial subtrahend.
   assign rem_shift = {rem_in, rad_in[SQ_W-1:SQ_W-2]};
   assign trial     = {1'b0, root_in, 2'b01};
   assign diff      = rem_shift - trial;

   // Keep the difference when the trial fits, and set the root bit.
   always_comb begin
      if (rem_shift >= trial) begin
         rem_out  = diff[REM_W-1:0];
         root_out = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
         rem_out  = rem_shift[REM_W-1:0];
         root_out = {root_in[ROOT_W-2:0], 1'b0};
      end
   end

   assign rad_out = {rad_in[SQ_W-3:0], 2'b00};

endmodule

// ----- hw/rtl/c2s_cordic_stage.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CORDIC vectoring step
// One micro-rotation that drives y toward zero and accumulates the angle.
// ---------------------------------------------------------------------------
module c2s_cordic_stage
   import c2s_pkg::*;
#(
   parameter int SHIFT = 0
)
(
   input  logic signed [CW-1:0]    x_in,
   input  logic signed [CW-1:0]    y_in,
   input  logic signed [ACC_W-1:0] acc_in,
   output logic signed [CW-1:0]    x_out,
   output logic signed [CW-1:0]    y_out,
   output logic signed [ACC_W-1:0] acc_out
);

   localparam logic signed [ACC_W-1:0] ANGLE = atan_q30(SHIFT);

   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;

   assign dx = y_in >>> SHIFT;
   assign dy = x_in >>> SHIFT;

   // Rotate clockwise while y is not negative, counterclockwise otherwise.
   always_comb begin
      if (!y_in[CW-1]) begin
         x_out   = x_in + dx;
         y_out   = y_in - dy;
         acc_out = acc_in + ANGLE;
      end else begin
         x_out   = x_in - dx;
         y_out   = y_in + dy;
         acc_out = acc_in - ANGLE;
      end
   end

endmodule

// ----- hw/rtl/cartesian_to_spherical.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cartesian to spherical converter
// Turns a position (x, y, z) into length, azimuth, elevation, horizontal
// length and z raised by a platform height, in a fully pipelined datapath.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake          Word
//  req      in         start / busy       pos_x, pos_y, pos_z
//  rsp      out        rsp_valid strobe   distance, azimuth, elevation,
//                                         horizontal_length, raised_z,
//                                         zero_vector
//  csr      in         csr_valid / ready  platform_height
//
// A new position is taken every cycle; busy stays low. Each word passes
// through four input and squaring stages, 24 square root digit stages,
// one CORDIC load stage, the CORDIC stages and one rounding stage. The
// receiver cannot stall the pipeline.
// Reset clears the valid bits and loads the platform height default.
// ---------------------------------------------------------------------------
`include "cartesian_to_spherical_assert.svh"

module cartesian_to_spherical
   import c2s_pkg::*;
#(
   parameter int CORDIC_STAGES = 18
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [POS_W-1:0]    req_pos_x,
   input  logic signed [POS_W-1:0]    req_pos_y,
   input  logic signed [POS_W-1:0]    req_pos_z,
   output logic                       rsp_valid,
   output logic [POS_W-1:0]           rsp_distance,
   output logic signed [AZ_W-1:0]     rsp_azimuth,
   output logic signed [EL_W-1:0]     rsp_elevation,
   output logic [POS_W-1:0]           rsp_horizontal_length,
   output logic signed [POS_W-1:0]    rsp_raised_z,
   output logic                       rsp_zero_vector,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [HEIGHT_W-1:0]        csr_data
);

   localparam int RND_SH = 30 - FRAC_BITS;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'((2 << FRAC_BITS) / 5);
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 << (RND_SH - 1));
   localparam logic signed [ACC_W-1:0] AZ_LIM =
      ACC_W'((PI_Q30 + (64'sd1 << (RND_SH - 1))) >>> RND_SH);
   localparam logic signed [ACC_W-1:0] EL_LIM =
      ACC_W'((HALF_PI_Q30 + (64'sd1 << (RND_SH - 1))) >>> RND_SH);
   localparam logic signed [ACC_W-1:0] PI_ACC = ACC_W'(PI_Q30);

   logic req_accept;

   // Configuration register.
   logic [HEIGHT_W-1:0] height_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;
   assign req_accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         height_ff <= csr_data;
      end
   end

   // Stage A: capture the input word.
   logic                    a_valid_ff;
   logic signed [POS_W-1:0] a_x_ff;
   logic signed [POS_W-1:0] a_y_ff;
   logic signed [POS_W-1:0] a_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      a_x_ff <= req_pos_x;
      a_y_ff <= req_pos_y;
      a_z_ff <= req_pos_z;
   end

   // Stage B: squares, folded operands and raised z.
   logic signed [SQ_W-1:0]  sq_x;
   logic signed [SQ_W-1:0]  sq_y;
   logic signed [SQ_W-1:0]  sq_z;
   logic signed [POS_W:0]   ext_x;
   logic signed [POS_W:0]   ext_y;
   logic signed [EXT_W-1:0] rz_sum;
   logic signed [POS_W-1:0] rz_sat;
   side_type                b_side_in;

   logic                    b_valid_ff;
   logic [SQ_W-1:0]         b_xx_ff;
   logic [SQ_W-1:0]         b_yy_ff;
   logic [SQ_W-1:0]         b_zz_ff;
   side_type                b_side_ff;

   assign sq_x  = a_x_ff * a_x_ff;
   assign sq_y  = a_y_ff * a_y_ff;
   assign sq_z  = a_z_ff * a_z_ff;
   assign ext_x = {a_x_ff[POS_W-1], a_x_ff};
   assign ext_y = {a_y_ff[POS_W-1], a_y_ff};
   assign rz_sum = {{(EXT_W-POS_W){a_z_ff[POS_W-1]}}, a_z_ff}
                 + $signed({{(EXT_W-HEIGHT_W){1'b0}}, height_ff});

   // Saturate the raised height to the field range.
   always_comb begin
      priority if (rz_sum > POS_MAX) begin
         rz_sat = POS_MAX[POS_W-1:0];
      end else if (rz_sum < POS_MIN) begin
         rz_sat = POS_MIN[POS_W-1:0];
      end else begin
         rz_sat = rz_sum[POS_W-1:0];
      end
   end

   // A vector with negative x is turned by pi before the CORDIC.
   always_comb begin
      b_side_in            = '0;
      b_side_in.x_neg      = a_x_ff[POS_W-1];
      b_side_in.y_neg      = a_y_ff[POS_W-1];
      b_side_in.ax         = a_x_ff[POS_W-1] ? -ext_x : ext_x;
      b_side_in.ay         = a_x_ff[POS_W-1] ? -ext_y : ext_y;
      b_side_in.pos_z      = a_z_ff;
      b_side_in.raised_z   = rz_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_xx_ff   <= sq_x;
      b_yy_ff   <= sq_y;
      b_zz_ff   <= sq_z;
      b_side_ff <= b_side_in;
   end

   // Stage C: horizontal sum of squares.
   logic            c_valid_ff;
   logic [SQ_W-1:0] c_hsq_ff;
   logic [SQ_W-1:0] c_zz_ff;
   side_type        c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_hsq_ff  <= b_xx_ff + b_yy_ff;
      c_zz_ff   <= b_zz_ff;
      c_side_ff <= b_side_ff;
   end

   // Stage D: full sum of squares and the zero flags; seeds the roots.
   logic [SQ_W-1:0] dsq_sum;
   side_type        d_side_in;

   assign dsq_sum = c_hsq_ff + c_zz_ff;

   always_comb begin
      d_side_in        = c_side_ff;
      d_side_in.h_zero = (c_hsq_ff == '0);
      d_side_in.zero   = (dsq_sum == '0);
   end

   // Square root pipeline, one root bit of each root per stage.
   logic              sv_ff     [0:ROOT_W];
   side_type          sside_ff  [0:ROOT_W];
   logic [REM_W-1:0]  hrem_ff   [0:ROOT_W];
   logic [ROOT_W-1:0] hroot_ff  [0:ROOT_W];
   logic [SQ_W-1:0]   hrad_ff   [0:ROOT_W];
   logic [REM_W-1:0]  drem_ff   [0:ROOT_W];
   logic [ROOT_W-1:0] droot_ff  [0:ROOT_W];
   logic [SQ_W-1:0]   drad_ff   [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else begin
         sv_ff[0] <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sside_ff[0] <= d_side_in;
      hrem_ff[0]  <= '0;
      hroot_ff[0] <= '0;
      hrad_ff[0]  <= c_hsq_ff;
      drem_ff[0]  <= '0;
      droot_ff[0] <= '0;
      drad_ff[0]  <= dsq_sum;
   end

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      logic [REM_W-1:0]  hrem_nx;
      logic [ROOT_W-1:0] hroot_nx;
      logic [SQ_W-1:0]   hrad_nx;
      logic [REM_W-1:0]  drem_nx;
      logic [ROOT_W-1:0] droot_nx;
      logic [SQ_W-1:0]   drad_nx;

      c2s_sqrt_stage u_hsqrt (
         .rem_in   (hrem_ff[g]),
         .root_in  (hroot_ff[g]),
         .rad_in   (hrad_ff[g]),
         .rem_out  (hrem_nx),
         .root_out (hroot_nx),
         .rad_out  (hrad_nx)
      );

      c2s_sqrt_stage u_dsqrt (
         .rem_in   (drem_ff[g]),
         .root_in  (droot_ff[g]),
         .rad_in   (drad_ff[g]),
         .rem_out  (drem_nx),
         .root_out (droot_nx),
         .rad_out  (drad_nx)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[g+1] <= 1'b0;
         end else begin
            sv_ff[g+1] <= sv_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         sside_ff[g+1] <= sside_ff[g];
         hrem_ff[g+1]  <= hrem_nx;
         hroot_ff[g+1] <= hroot_nx;
         hrad_ff[g+1]  <= hrad_nx;
         drem_ff[g+1]  <= drem_nx;
         droot_ff[g+1] <= droot_nx;
         drad_ff[g+1]  <= drad_nx;
      end
   end

   // CORDIC load: scale both vectors up and preset the azimuth angle.
   side_type                ld_side;
   logic signed [ACC_W-1:0] az_base;

   always_comb begin
      ld_side            = sside_ff[ROOT_W];
      ld_side.distance   = droot_ff[ROOT_W];
      ld_side.horizontal = hroot_ff[ROOT_W];
      if (!ld_side.x_neg) begin
         az_base = '0;
      end else if (ld_side.y_neg) begin
         az_base = -PI_ACC;
      end else begin
         az_base = PI_ACC;
      end
   end

   logic                    cv_ff    [0:CORDIC_STAGES];
   side_type                cside_ff [0:CORDIC_STAGES];
   logic signed [CW-1:0]    azx_ff   [0:CORDIC_STAGES];
   logic signed [CW-1:0]    azy_ff   [0:CORDIC_STAGES];
   logic signed [ACC_W-1:0] aza_ff   [0:CORDIC_STAGES];
   logic signed [CW-1:0]    elx_ff   [0:CORDIC_STAGES];
   logic signed [CW-1:0]    ely_ff   [0:CORDIC_STAGES];
   logic signed [ACC_W-1:0] ela_ff   [0:CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else begin
         cv_ff[0] <= sv_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      cside_ff[0] <= ld_side;
      azx_ff[0]   <= {{(CW-POS_W-1-SCALE_SH){ld_side.ax[POS_W]}}, ld_side.ax,
                      {SCALE_SH{1'b0}}};
      azy_ff[0]   <= {{(CW-POS_W-1-SCALE_SH){ld_side.ay[POS_W]}}, ld_side.ay,
                      {SCALE_SH{1'b0}}};
      aza_ff[0]   <= az_base;
      elx_ff[0]   <= {{(CW-ROOT_W-SCALE_SH){1'b0}}, ld_side.horizontal,
                      {SCALE_SH{1'b0}}};
      ely_ff[0]   <= {{(CW-POS_W-SCALE_SH){ld_side.pos_z[POS_W-1]}}, ld_side.pos_z,
                      {SCALE_SH{1'b0}}};
      ela_ff[0]   <= '0;
   end

   // CORDIC stages, azimuth and elevation side by side.
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      logic signed [CW-1:0]    azx_nx;
      logic signed [CW-1:0]    azy_nx;
      logic signed [ACC_W-1:0] aza_nx;
      logic signed [CW-1:0]    elx_nx;
      logic signed [CW-1:0]    ely_nx;
      logic signed [ACC_W-1:0] ela_nx;

      c2s_cordic_stage #(.SHIFT(g)) u_az (
         .x_in    (azx_ff[g]),
         .y_in    (azy_ff[g]),
         .acc_in  (aza_ff[g]),
         .x_out   (azx_nx),
         .y_out   (azy_nx),
         .acc_out (aza_nx)
      );

      c2s_cordic_stage #(.SHIFT(g)) u_el (
         .x_in    (elx_ff[g]),
         .y_in    (ely_ff[g]),
         .acc_in  (ela_ff[g]),
         .x_out   (elx_nx),
         .y_out   (ely_nx),
         .acc_out (ela_nx)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[g+1] <= 1'b0;
         end else begin
            cv_ff[g+1] <= cv_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         cside_ff[g+1] <= cside_ff[g];
         azx_ff[g+1]   <= azx_nx;
         azy_ff[g+1]   <= azy_nx;
         aza_ff[g+1]   <= aza_nx;
         elx_ff[g+1]   <= elx_nx;
         ely_ff[g+1]   <= ely_nx;
         ela_ff[g+1]   <= ela_nx;
      end
   end

   // Output stage: round half up, clamp, and zero the angles where needed.
   side_type                o_side;
   logic signed [ACC_W-1:0] az_sum;
   logic signed [ACC_W-1:0] el_sum;
   logic signed [ACC_W-1:0] az_rnd;
   logic signed [ACC_W-1:0] el_rnd;
   logic signed [ACC_W-1:0] az_cl;
   logic signed [ACC_W-1:0] el_cl;

   assign o_side = cside_ff[CORDIC_STAGES];
   assign az_sum = aza_ff[CORDIC_STAGES] + RND_HALF;
   assign el_sum = ela_ff[CORDIC_STAGES] + RND_HALF;
   assign az_rnd = az_sum >>> RND_SH;
   assign el_rnd = el_sum >>> RND_SH;

   always_comb begin
      priority if (o_side.h_zero) begin
         az_cl = '0;
      end else if (az_rnd > AZ_LIM) begin
         az_cl = AZ_LIM;
      end else if (az_rnd < -AZ_LIM) begin
         az_cl = -AZ_LIM;
      end else begin
         az_cl = az_rnd;
      end
   end

   always_comb begin
      priority if (o_side.zero) begin
         el_cl = '0;
      end else if (el_rnd > EL_LIM) begin
         el_cl = EL_LIM;
      end else if (el_rnd < -EL_LIM) begin
         el_cl = -EL_LIM;
      end else begin
         el_cl = el_rnd;
      end
   end

   logic                    rsp_valid_ff;
   logic [POS_W-1:0]        rsp_distance_ff;
   logic signed [AZ_W-1:0]  rsp_azimuth_ff;
   logic signed [EL_W-1:0]  rsp_elevation_ff;
   logic [POS_W-1:0]        rsp_horizontal_ff;
   logic signed [POS_W-1:0] rsp_raised_z_ff;
   logic                    rsp_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cv_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_distance_ff   <= o_side.distance;
      rsp_azimuth_ff    <= az_cl[AZ_W-1:0];
      rsp_elevation_ff  <= el_cl[EL_W-1:0];
      rsp_horizontal_ff <= o_side.horizontal;
      rsp_raised_z_ff   <= o_side.raised_z;
      rsp_zero_ff       <= o_side.zero;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_distance          = rsp_distance_ff;
   assign rsp_azimuth           = rsp_azimuth_ff;
   assign rsp_elevation         = rsp_elevation_ff;
   assign rsp_horizontal_length = rsp_horizontal_ff;
   assign rsp_raised_z          = rsp_raised_z_ff;
   assign rsp_zero_vector       = rsp_zero_ff;

   // A zero vector has no length and no angles.
   `C2S_ASSERT_IMP(a_zero_word, clock, reset, rsp_valid && rsp_zero_vector,
      rsp_distance == '0 && rsp_horizontal_length == '0 &&
      rsp_azimuth == '0 && rsp_elevation == '0)

   // The horizontal projection never exceeds the full length.
   `C2S_ASSERT_IMP(a_horiz_le_dist, clock, reset, rsp_valid,
      rsp_horizontal_length <= rsp_distance)

   // Without a horizontal part the azimuth is zero.
   `C2S_ASSERT_IMP(a_no_horiz_az, clock, reset, rsp_valid && rsp_horizontal_length == '0,
      rsp_azimuth == '0)

   // The zero flag and a nonzero length never appear together.
   `C2S_ASSERT_IMP(a_zero_flag, clock, reset, rsp_valid && rsp_distance != '0,
      !rsp_zero_vector)

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cartesian to spherical converter testbench
// Feeds positions through the start/busy port, first from a directed table
// and then at random, and checks every result word against a bit-exact
// software model of the square roots, the vectoring CORDIC and the raised z,
// or the typed zero word; the height is rewritten between phases while idle.
// ---------------------------------------------------------------------------
module tb;
   import c2s_pkg::*;

   localparam int  STAGES     = 18;
   localparam int  LATENCY    = 30 + STAGES;
   localparam int  HEIGHT_MAX = 1048576;
   localparam int  RST_HEIGHT = 26214;

   typedef struct {
      logic [POS_W-1:0]        distance;
      logic signed [AZ_W-1:0]  azimuth;
      logic signed [EL_W-1:0]  elevation;
      logic [POS_W-1:0]        horizontal;
      logic signed [POS_W-1:0] raised_z;
      logic                    zero;
   } sph_word_type;

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      bit                      typed;
      sph_word_type            want;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [POS_W-1:0] req_pos_x;
   logic signed [POS_W-1:0] req_pos_y;
   logic signed [POS_W-1:0] req_pos_z;
   logic                    rsp_valid;
   logic [POS_W-1:0]        rsp_distance;
   logic signed [AZ_W-1:0]  rsp_azimuth;
   logic signed [EL_W-1:0]  rsp_elevation;
   logic [POS_W-1:0]        rsp_horizontal_length;
   logic signed [POS_W-1:0] rsp_raised_z;
   logic                    rsp_zero_vector;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [HEIGHT_W-1:0]     csr_data;

   sph_word_type      pending_words[$];
   logic [HEIGHT_W-1:0] height_model;
   int                errors;
   bit                steady_feed;

   // atan(2^-i) in Q30, truncated.
   longint atan_tab[STAGES] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191};

   cartesian_to_spherical dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_pos_x             (req_pos_x),
      .req_pos_y             (req_pos_y),
      .req_pos_z             (req_pos_z),
      .rsp_valid             (rsp_valid),
      .rsp_distance          (rsp_distance),
      .rsp_azimuth           (rsp_azimuth),
      .rsp_elevation         (rsp_elevation),
      .rsp_horizontal_length (rsp_horizontal_length),
      .rsp_raised_z          (rsp_raised_z),
      .rsp_zero_vector       (rsp_zero_vector),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Floor square root, one result bit per pass.
   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Vectoring CORDIC angle in Q30; operands scaled by 2^32 first.
   function automatic longint vector_angle(input longint vx, input longint vy);
      longint acc;
      longint dx;
      longint dy;
      acc = 0;
      vx  = vx <<< SCALE_SH;
      vy  = vy <<< SCALE_SH;
      for (int i = 0; i < STAGES; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx  = vx + dx;
            vy  = vy - dy;
            acc = acc + atan_tab[i];
         end else begin
            vx  = vx - dx;
            vy  = vy + dy;
            acc = acc - atan_tab[i];
         end
      end
      return acc;
   endfunction

   // Q30 to 16 fraction bits, rounded half up.
   function automatic longint round_q16(input longint a);
      return (a + (64'sd1 <<< 13)) >>> 14;
   endfunction

   function automatic longint clamp_angle(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic sph_word_type predict_spherical(input logic signed [POS_W-1:0] px,
                                                      input logic signed [POS_W-1:0] py,
                                                      input logic signed [POS_W-1:0] pz,
                                                      input logic [HEIGHT_W-1:0] hgt);
      sph_word_type     w;
      longint           x;
      longint           y;
      longint           z;
      longint           ang;
      longint           rz;
      longint unsigned  hsq;
      longint unsigned  dsq;
      longint unsigned  horiz;
      x     = px;
      y     = py;
      z     = pz;
      hsq   = x * x + y * y;
      dsq   = hsq + z * z;
      horiz = floor_root(hsq);
      w.distance   = POS_W'(floor_root(dsq));
      w.horizontal = POS_W'(horiz);
      w.zero       = (dsq == 0);
      w.azimuth    = '0;
      w.elevation  = '0;
      if (hsq != 0) begin
         if (x < 0)
            ang = (y >= 0 ? PI_Q30 : -PI_Q30) + vector_angle(-x, -y);
         else
            ang = vector_angle(x, y);
         w.azimuth = AZ_W'(clamp_angle(round_q16(ang), round_q16(PI_Q30)));
      end
      if (dsq != 0) begin
         ang = vector_angle(longint'(horiz), z);
         w.elevation = EL_W'(clamp_angle(round_q16(ang), round_q16(HALF_PI_Q30)));
      end
      rz = z + longint'(hgt);
      if (rz > 64'sd8388607) rz = 64'sd8388607;
      if (rz < -64'sd8388608) rz = -64'sd8388608;
      w.raised_z = POS_W'(rz);
      return w;
   endfunction

   // Gap length: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      if (steady_feed) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Present one position and hold it until taken.
   task automatic send_position(input logic signed [POS_W-1:0] px,
                                input logic signed [POS_W-1:0] py,
                                input logic signed [POS_W-1:0] pz,
                                input bit typed, input sph_word_type want);
      int gap;
      start     <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      do @(posedge clock); while (busy);
      if (typed) pending_words.push_back(want);
      else pending_words.push_back(predict_spherical(px, py, pz, height_model));
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Rewrite the platform height once the pipeline has drained.
   task automatic write_height(input logic [HEIGHT_W-1:0] value);
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat ($urandom_range(4)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      height_model = value;
      csr_valid <= 1'b0;
      csr_data  <= HEIGHT_W'($urandom);
   endtask

   function automatic logic signed [POS_W-1:0] random_coord();
      int r;
      r = $urandom_range(99);
      if (r < 45) return POS_W'($urandom);
      if (r < 70) return POS_W'($signed($urandom_range(2000)) - 1000);
      if (r < 80) return '0;
      if (r < 90) return (r & 1) ? POS_W'(24'sh7FFFFF - $urandom_range(50))
                                 : POS_W'(24'sh800000 + $urandom_range(50));
      return POS_W'($signed($urandom_range(262144)) - 131072);
   endfunction

   task automatic random_burst(input int count);
      sph_word_type none;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) steady_feed = ($urandom_range(3) == 0);
         send_position(random_coord(), random_coord(), random_coord(), 1'b0, none);
      end
      steady_feed = 1'b0;
   endtask

   // Result checker: every strobed word against the oldest expectation.
   always @(posedge clock) begin
      sph_word_type w;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result word at %0t", $realtime);
         end else begin
            w = pending_words.pop_front();
            if (rsp_distance !== w.distance || rsp_azimuth !== w.azimuth ||
                rsp_elevation !== w.elevation || rsp_horizontal_length !== w.horizontal ||
                rsp_raised_z !== w.raised_z || rsp_zero_vector !== w.zero) begin
               errors++;
               if (errors <= 10)
                  $display("Mismatch at %0t: exp d=%0d az=%0d el=%0d h=%0d rz=%0d z=%0b,",
                     $realtime, w.distance, w.azimuth, w.elevation, w.horizontal,
                     w.raised_z, w.zero,
                     " got d=%0d az=%0d el=%0d h=%0d rz=%0d z=%0b",
                     rsp_distance, rsp_azimuth, rsp_elevation,
                     rsp_horizontal_length, rsp_raised_z, rsp_zero_vector);
            end
         end
      end
   end

   // Run limit.
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      sph_word_type none;
      errors       = 0;
      steady_feed  = 1'b0;
      height_model = HEIGHT_W'(RST_HEIGHT);
      reset        = 1'b1;
      start        = 1'b0;
      req_pos_x    = '0;
      req_pos_y    = '0;
      req_pos_z    = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      none         = '{default: '0};

      // Directed table; only the zero vector has its result typed in.
      row = '{x: 0, y: 0, z: 0, typed: 1, want: none};
      row.want.raised_z = POS_W'(RST_HEIGHT);
      row.want.zero     = 1'b1;
      rows.push_back(row);
      row.typed = 0;
      row.x = 0;          row.y = 0;          row.z = 24'sh7FFFFF; rows.push_back(row);
      row.x = 0;          row.y = 0;          row.z = 24'sh800000; rows.push_back(row);
      row.x = 0;          row.y = 0;          row.z = -1;          rows.push_back(row);
      row.x = 24'sh7FFFFF; row.y = 0;         row.z = 0;           rows.push_back(row);
      row.x = 24'sh800000; row.y = 0;         row.z = 0;           rows.push_back(row);
      row.x = 0;          row.y = 24'sh7FFFFF; row.z = 0;          rows.push_back(row);
      row.x = 0;          row.y = 24'sh800000; row.z = 0;          rows.push_back(row);
      row.x = -1;         row.y = 0;          row.z = 0;           rows.push_back(row);
      row.x = -1;         row.y = -1;         row.z = 0;           rows.push_back(row);
      row.x = -1;         row.y = 1;          row.z = 1;           rows.push_back(row);
      row.x = 1;          row.y = 0;          row.z = 0;           rows.push_back(row);
      row.x = 3;          row.y = 4;          row.z = 12;          rows.push_back(row);
      row.x = 24'sh7FFFFF; row.y = 24'sh7FFFFF; row.z = 24'sh7FFFFF; rows.push_back(row);
      row.x = 24'sh800000; row.y = 24'sh800000; row.z = 24'sh800000; rows.push_back(row);
      row.x = 24'sh800000; row.y = 24'sh7FFFFF; row.z = 24'sh800000; rows.push_back(row);
      row.x = 24'sh7FFFFF; row.y = 24'sh800000; row.z = 65536;      rows.push_back(row);
      row.x = 24'sh555555; row.y = 24'shAAAAAA; row.z = 24'sh5A5A5A; rows.push_back(row);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_position(rows[i].x, rows[i].y, rows[i].z, rows[i].typed,
                                      rows[i].want);

      // Extremes of the height, each with z at the ends of its range.
      write_height('0);
      send_position(0, 0, 24'sh7FFFFF, 1'b0, none);
      send_position(0, 0, 24'sh800000, 1'b0, none);
      write_height(HEIGHT_W'(HEIGHT_MAX));
      send_position(0, 0, 24'sh7FFFFF, 1'b0, none);
      send_position(0, 0, POS_W'(24'sh7FFFFF - HEIGHT_MAX), 1'b0, none);
      send_position(0, 0, 24'sh800000, 1'b0, none);

      // Random phases over several heights.
      random_burst(200);
      write_height('0);
      random_burst(200);
      write_height(HEIGHT_W'($urandom_range(HEIGHT_MAX)));
      random_burst(200);
      write_height(HEIGHT_W'(RST_HEIGHT));
      random_burst(200);
      write_height(HEIGHT_W'($urandom_range(HEIGHT_MAX)));
      random_burst(270);

      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
